@@ rtl/journal_record_validator_defines.svh @@
// Assertion macros for the journal record validator
`ifndef JOURNAL_RECORD_VALIDATOR_DEFINES_SVH
`define JOURNAL_RECORD_VALIDATOR_DEFINES_SVH

// check c in the cycle after a
`define JRV_ASSERT_NEXT(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);

// check c in the same cycle as a
`define JRV_ASSERT_NOW(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);

`endif

@@ rtl/jrv_pkg.sv @@
// Shared constants and types of the journal record validator
`default_nettype none
package jrv_pkg;
  localparam int BATCH_SLOTS = 64;
  localparam int SLOT_BITS = 16;
  localparam int IDX_W = $clog2(BATCH_SLOTS);
  localparam logic [31:0] CRC_POLY = 32'hedb88320;
  localparam logic [63:0] JRN_MAGIC = 64'h4e52554f4a53464b;
  localparam logic [31:0] EVB_MAGIC = 32'h48435442;
  localparam logic [11:0] OLD_AT = 12'd32;
  localparam logic [11:0] NEW_AT = 12'd64;
  localparam logic [11:0] RESV_AT = 12'd96;
  localparam logic [11:0] SLOTS_AT = 12'd104;
  localparam logic [11:0] TAIL_AT = 12'(104 + 4 * BATCH_SLOTS);
  localparam logic [11:0] SUM_AT = 12'd4092;
  localparam logic [11:0] LAST_POS = 12'd4095;
  localparam logic [31:0] OP_FILL = 32'd1;
  localparam logic [31:0] OP_INVALIDATE = 32'd2;
  localparam logic [31:0] OP_EVICT = 32'd3;
  localparam logic [31:0] OP_RETIRE = 32'd4;
  localparam logic [1:0] OVR_CLEAN = 2'd0;
  localparam logic [1:0] OVR_RECOVER = 2'd1;
  localparam logic [1:0] OVR_INVALID = 2'd2;

  typedef struct packed {
    logic init;
    logic step;
    logic bit_in;
    logic blk_en;
    logic old_en;
    logic new_en;
  } crc_ctl_t;

  typedef struct packed {
    logic nz;
    logic ino;
    logic ofs;
    logic gen;
    logic crc;
  } entry_flags_t;
endpackage
`default_nettype wire

@@ rtl/jrv_ram.sv @@
// Generic single-write, registered-read RAM
`default_nettype none
module jrv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ rtl/jrv_crc.sv @@
// Bit-serial CRC-32 unit for the block and the two index entries
`default_nettype none
module jrv_crc (
  input  logic               clk,
  input  jrv_pkg::crc_ctl_t  ctl,
  output logic [31:0]        block_crc,
  output logic [31:0]        old_crc,
  output logic [31:0]        new_crc
);
  function automatic logic [31:0] crc_bit(input logic [31:0] c, input logic b);
    logic fb;
    fb = c[0] ^ b;
    return {1'b0, c[31:1]} ^ (fb ? jrv_pkg::CRC_POLY : 32'h0);
  endfunction

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      block_crc <= '1;
      old_crc <= '1;
      new_crc <= '1;
    end else if (ctl.step) begin
      if (ctl.blk_en) begin
        block_crc <= crc_bit(block_crc, ctl.bit_in);
      end
      if (ctl.old_en) begin
        old_crc <= crc_bit(old_crc, ctl.bit_in);
      end
      if (ctl.new_en) begin
        new_crc <= crc_bit(new_crc, ctl.bit_in);
      end
    end
  end
endmodule
`default_nettype wire

@@ rtl/journal_record_validator.sv @@
// Top level: journal block validator with byte sequencer and result register
// Each byte steps through accept, field check, 8 CRC bit steps, advance.
// A batch slot entry adds a duplicate scan over every earlier slot: a read
// (S_DUP) and a compare (S_DCMP) per earlier slot through the slot RAM.
// The advance cycle of the last byte loads the result; it waits while a result is unread.
// Synchronous active-high reset clears usable_slots and restarts at byte 0.
`default_nettype none
`include "journal_record_validator_defines.svh"
module journal_record_validator (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        journal_clean,
  output logic        crc_ok,
  output logic        layout_ok,
  output logic        state_prepared,
  output logic [63:0] sequence_number,
  output logic [2:0]  operation_kind,
  output logic [31:0] record_slot,
  output logic        batch_present,
  output logic [31:0] evict_count,
  output logic [1:0]  overall
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_CRC = 3'd2;
  localparam logic [2:0] S_DUP = 3'd3;
  localparam logic [2:0] S_DCMP = 3'd4;
  localparam logic [2:0] S_NEXT = 3'd5;

  localparam int IW = jrv_pkg::IDX_W;
  localparam int SB = jrv_pkg::SLOT_BITS;

  logic [2:0] state;
  logic [15:0] usable_slots;
  logic [11:0] pos;
  logic [63:0] fa;
  logic [7:0] byte_r;
  logic [2:0] bitcnt;
  logic [63:0] seq_v;
  logic [31:0] op_v, slot_v, cnt_v;
  logic all_clear, magic_ok, version_ok, state_ok, resv_zero, batch_magic, batch_valid;
  jrv_pkg::entry_flags_t eold, enew;
  logic blk_en, old_en, new_en;
  logic [SB-1:0] cur_slot;
  logic [IW-1:0] cur_idx, dup_j;
  logic need_dup;
  logic ram_we;
  logic [SB-1:0] ram_rdata;
  logic [31:0] block_crc, old_crc, new_crc;
  jrv_pkg::crc_ctl_t crc_ctl;
  logic load_result;
  logic block_init;

  logic [31:0] w;
  logic [11:0] spos;
  logic in_slots, slot_done, idx_in;
  logic [IW-1:0] idx;
  logic in_old, in_new;
  logic [4:0] eoff;
  logic crc_good, fill, removal, evict_ok, layout;
  logic [1:0] ovr;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'h0 : {16'h0, usable_slots};
  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      usable_slots <= '0;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      usable_slots <= pwdata[15:0];
    end
  end

  assign w = fa[63:32];
  assign spos = pos - jrv_pkg::SLOTS_AT;
  assign in_slots = (pos >= jrv_pkg::SLOTS_AT) && (pos < jrv_pkg::TAIL_AT);
  assign slot_done = in_slots && (spos[1:0] == 2'd3);
  assign idx = spos[IW+1:2];
  assign idx_in = {{(32-IW){1'b0}}, idx} < cnt_v;
  assign in_old = (pos >= jrv_pkg::OLD_AT) && (pos < jrv_pkg::NEW_AT);
  assign in_new = (pos >= jrv_pkg::NEW_AT) && (pos < jrv_pkg::RESV_AT);
  assign eoff = pos[4:0];
  assign ram_we = (state == S_CHECK) && slot_done && idx_in;

  jrv_ram #(.WIDTH(SB), .DEPTH(jrv_pkg::BATCH_SLOTS)) u_slots (
    .clk(clk), .we(ram_we), .waddr(idx), .wdata(w[SB-1:0]),
    .raddr(dup_j), .rdata(ram_rdata)
  );

  assign load_result = (state == S_NEXT) && (pos == jrv_pkg::LAST_POS) &&
                       !(out_valid && !out_ready);
  assign block_init = rst || load_result;

  always_comb begin
    crc_ctl.init = block_init;
    crc_ctl.step = (state == S_CRC);
    crc_ctl.bit_in = byte_r[0];
    crc_ctl.blk_en = blk_en;
    crc_ctl.old_en = old_en;
    crc_ctl.new_en = new_en;
  end

  jrv_crc u_crc (
    .clk(clk), .ctl(crc_ctl),
    .block_crc(block_crc), .old_crc(old_crc), .new_crc(new_crc)
  );

  function automatic jrv_pkg::entry_flags_t entry_upd(
    input jrv_pkg::entry_flags_t e, input logic [4:0] off, input logic [7:0] b,
    input logic [63:0] f, input logic [31:0] c);
    jrv_pkg::entry_flags_t r;
    r = e;
    if (b != 8'h0) r.nz = 1'b1;
    unique case (off)
      5'd7: r.ino = (f != 64'h0);
      5'd15: r.ofs = (f[11:0] == 12'h0);
      5'd23: r.gen = (f != 64'h0);
      5'd31: r.crc = (f[63:32] == ~c);
      default: r = r;
    endcase
    return r;
  endfunction

  always_comb begin
    crc_good = (w == ~block_crc);
    fill = (op_v == jrv_pkg::OP_FILL);
    removal = (op_v == jrv_pkg::OP_INVALIDATE) || (op_v == jrv_pkg::OP_EVICT) ||
              (op_v == jrv_pkg::OP_RETIRE);
    evict_ok = resv_zero || ((op_v == jrv_pkg::OP_EVICT) && batch_magic && batch_valid);
    layout = magic_ok && version_ok && state_ok && (seq_v != 64'h0) &&
             (slot_v < {16'h0, usable_slots}) && (fill || removal) && evict_ok &&
             ((fill && !eold.nz && enew.ino && enew.ofs && enew.gen && enew.crc) ||
              (removal && eold.ino && eold.ofs && eold.gen && eold.crc && !enew.nz));
    if (all_clear) begin
      ovr = (usable_slots == 16'h0) ? jrv_pkg::OVR_INVALID : jrv_pkg::OVR_CLEAN;
    end else begin
      ovr = (crc_good && (usable_slots != 16'h0) && layout) ? jrv_pkg::OVR_RECOVER
                                                            : jrv_pkg::OVR_INVALID;
    end
  end

  always_ff @(posedge clk) begin
    if (block_init) begin
      pos <= '0;
      fa <= '0;
      seq_v <= '0;
      op_v <= '0;
      slot_v <= '0;
      cnt_v <= '0;
      all_clear <= 1'b1;
      magic_ok <= 1'b0;
      version_ok <= 1'b0;
      state_ok <= 1'b0;
      resv_zero <= 1'b1;
      batch_magic <= 1'b0;
      batch_valid <= 1'b1;
      eold <= '0;
      enew <= '0;
    end
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load_result) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            fa <= {data_byte, fa[63:8]};
            byte_r <= data_byte;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (byte_r != 8'h0) all_clear <= 1'b0;
          blk_en <= pos < jrv_pkg::SUM_AT;
          old_en <= (pos >= jrv_pkg::OLD_AT) && (pos < jrv_pkg::OLD_AT + 12'd28);
          new_en <= (pos >= jrv_pkg::NEW_AT) && (pos < jrv_pkg::NEW_AT + 12'd28);
          bitcnt <= '0;
          need_dup <= 1'b0;
          unique case (pos)
            12'd7: magic_ok <= (fa == jrv_pkg::JRN_MAGIC);
            12'd11: version_ok <= (w == 32'd1);
            12'd15: state_ok <= (w == 32'd1);
            12'd23: seq_v <= fa;
            12'd27: op_v <= w;
            12'd31: slot_v <= w;
            default: ;
          endcase
          if (in_old) eold <= entry_upd(eold, eoff, byte_r, fa, old_crc);
          if (in_new) enew <= entry_upd(enew, eoff, byte_r, fa, new_crc);
          if ((pos >= jrv_pkg::RESV_AT) && (pos < jrv_pkg::SUM_AT)) begin
            if (byte_r != 8'h0) resv_zero <= 1'b0;
            if (pos == jrv_pkg::RESV_AT + 12'd3) begin
              batch_magic <= (w == jrv_pkg::EVB_MAGIC);
            end else if (pos == jrv_pkg::RESV_AT + 12'd7) begin
              cnt_v <= w;
              if ((w < 32'd2) || (w > 32'(jrv_pkg::BATCH_SLOTS))) batch_valid <= 1'b0;
            end else if (slot_done) begin
              if (idx_in) begin
                if ((idx == '0) && (w != slot_v)) batch_valid <= 1'b0;
                if (w >= {16'h0, usable_slots}) batch_valid <= 1'b0;
                cur_slot <= w[SB-1:0];
                cur_idx <= idx;
                dup_j <= '0;
                need_dup <= (idx != '0);
              end else if (w != 32'h0) begin
                batch_valid <= 1'b0;
              end
            end else if ((pos >= jrv_pkg::TAIL_AT) && (byte_r != 8'h0)) begin
              batch_valid <= 1'b0;
            end
          end
          state <= S_CRC;
        end
        S_CRC: begin
          byte_r <= {1'b0, byte_r[7:1]};
          bitcnt <= bitcnt + 3'd1;
          if (bitcnt == 3'd7) begin
            state <= need_dup ? S_DUP : S_NEXT;
          end
        end
        S_DUP: begin
          state <= S_DCMP;
        end
        S_DCMP: begin
          if (ram_rdata == cur_slot) batch_valid <= 1'b0;
          if (dup_j == cur_idx - IW'(1)) begin
            state <= S_NEXT;
          end else begin
            dup_j <= dup_j + IW'(1);
            state <= S_DUP;
          end
        end
        S_NEXT: begin
          if (pos != jrv_pkg::LAST_POS) begin
            pos <= pos + 12'd1;
            state <= S_IDLE;
          end else if (!(out_valid && !out_ready)) begin
            journal_clean <= all_clear;
            crc_ok <= crc_good;
            layout_ok <= layout;
            state_prepared <= state_ok;
            sequence_number <= seq_v;
            operation_kind <= (fill || removal) ? op_v[2:0] : 3'd0;
            record_slot <= slot_v;
            batch_present <= batch_magic;
            evict_count <= batch_magic ? cnt_v : 32'h0;
            overall <= ovr;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `JRV_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")
  `JRV_ASSERT_NOW(a_overall_code, out_valid, overall <= jrv_pkg::OVR_INVALID, "bad overall code")
  `JRV_ASSERT_NOW(a_recover_ok, out_valid && (overall == jrv_pkg::OVR_RECOVER),
    crc_ok && layout_ok && !journal_clean, "recovery without passing checks")
endmodule
`default_nettype wire
